### rtl/spq_pkg.sv
// ----------------------------------------------------------------------------
// spq_pkg: shared definitions for the sorted priority queue
// Word widths, operation and status codes, and the command that the top level
// broadcasts to every cell of the chain.
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int DEF_CAPACITY = 16;
  localparam int WORD_W       = 32;
  localparam int COUNT_W      = 5;
  localparam int STATUS_W     = 2;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  typedef logic signed [WORD_W-1:0] word_t;

  // Broadcast to every cell. The insert and remove enables are already
  // qualified against a full or empty queue.
  typedef struct packed {
    logic  ins;
    logic  rem;
    word_t value;
    word_t prio;
  } spq_cmd_t;

endpackage

### rtl/spq_cell.sv
// ----------------------------------------------------------------------------
// spq_cell: one slot of the sorted chain
// Holds one value and priority pair. On an insert it keeps its pair, takes
// the new pair or takes its upper neighbor's pair; on a remove it takes its
// lower neighbor's pair.
// ----------------------------------------------------------------------------
module spq_cell (
  input  logic              clk,
  input  spq_pkg::spq_cmd_t cmd,
  input  logic              occupied,
  input  logic              prev_take,
  input  spq_pkg::word_t    prev_value,
  input  spq_pkg::word_t    prev_prio,
  input  spq_pkg::word_t    next_value,
  input  spq_pkg::word_t    next_prio,
  output logic              take,
  output spq_pkg::word_t    value,
  output spq_pkg::word_t    prio
);
  import spq_pkg::*;

  word_t value_next;
  word_t prio_next;

  // A slot at or behind the insertion point: empty, or holding a strictly
  // lower priority, so equal priorities stay ahead of the new word.
  assign take = !occupied || (prio < cmd.prio);

  always_comb begin
    value_next = value;
    prio_next  = prio;
    if (cmd.ins && take) begin
      if (prev_take) begin
        value_next = prev_value;
        prio_next  = prev_prio;
      end else begin
        value_next = cmd.value;
        prio_next  = cmd.prio;
      end
    end else if (cmd.rem) begin
      value_next = next_value;
      prio_next  = next_prio;
    end
  end

  always_ff @(posedge clk) begin
    value <= value_next;
    prio  <= prio_next;
  end

endmodule

### rtl/sorted_priority_queue.sv
// ----------------------------------------------------------------------------
// sorted_priority_queue: bounded priority queue kept sorted in a cell chain
//
//   channel  | handshake           | word
//   ---------+---------------------+-----------------------------------------
//   command  | start / busy        | opcode, item_value, item_priority
//   result   | done (one cycle)    | status, head_value, head_priority,
//            |                     | is_empty, entry_count
//
// Each command is handled at once: all cells compare against the new priority
// at once and shift in the same edge, so busy stays low and a command may be
// issued in every cycle. The result appears on the cycle after the command.
// Reset empties the queue; slot contents are not cleared. The receiver cannot
// stall, and has no ready input; status is valid only while done is high.
// ----------------------------------------------------------------------------
module sorted_priority_queue #(
  parameter int CAPACITY = spq_pkg::DEF_CAPACITY
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  logic                           opcode,
  input  spq_pkg::word_t                 item_value,
  input  spq_pkg::word_t                 item_priority,
  output logic                           done,
  output logic [spq_pkg::STATUS_W-1:0]   status,
  output spq_pkg::word_t                 head_value,
  output spq_pkg::word_t                 head_priority,
  output logic                           is_empty,
  output logic [spq_pkg::COUNT_W-1:0]    entry_count
);
  import spq_pkg::*;

  localparam int CNT_W = $clog2(CAPACITY + 1);

  logic [CNT_W-1:0]    count;
  logic [CNT_W-1:0]    count_next;
  logic [STATUS_W-1:0] status_next;
  logic                accept;
  logic                full;
  logic                empty;
  spq_cmd_t            cmd;

  logic  cell_take  [CAPACITY];
  word_t cell_value [CAPACITY];
  word_t cell_prio  [CAPACITY];

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign full   = (count == CNT_W'(CAPACITY));
  assign empty  = (count == '0);

  always_comb begin
    cmd.ins     = 1'b0;
    cmd.rem     = 1'b0;
    cmd.value   = item_value;
    cmd.prio    = item_priority;
    count_next  = count;
    status_next = ST_DONE;
    if (accept) begin
      if (opcode == OP_INSERT) begin
        if (full) begin
          status_next = ST_FULL;
        end else begin
          cmd.ins    = 1'b1;
          count_next = count + 1'b1;
        end
      end else begin
        if (empty) begin
          status_next = ST_EMPTY;
        end else begin
          cmd.rem    = 1'b1;
          count_next = count - 1'b1;
        end
      end
    end
  end

  genvar i;
  generate
    for (i = 0; i < CAPACITY; i++) begin : g_cell
      logic  prev_take;
      word_t prev_value;
      word_t prev_prio;
      word_t next_value;
      word_t next_prio;

      if (i == 0) begin : g_head
        assign prev_take  = 1'b0;
        assign prev_value = '0;
        assign prev_prio  = '0;
      end else begin : g_body
        assign prev_take  = cell_take[i-1];
        assign prev_value = cell_value[i-1];
        assign prev_prio  = cell_prio[i-1];
      end

      // The tail slot falls out of range on a remove, so its contents do
      // not matter.
      if (i == CAPACITY - 1) begin : g_tail
        assign next_value = '0;
        assign next_prio  = '0;
      end else begin : g_link
        assign next_value = cell_value[i+1];
        assign next_prio  = cell_prio[i+1];
      end

      spq_cell u_cell (
        .clk        (clk),
        .cmd        (cmd),
        .occupied   (CNT_W'(i) < count),
        .prev_take  (prev_take),
        .prev_value (prev_value),
        .prev_prio  (prev_prio),
        .next_value (next_value),
        .next_prio  (next_prio),
        .take       (cell_take[i]),
        .value      (cell_value[i]),
        .prio       (cell_prio[i])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done  <= 1'b0;
    end else begin
      count <= count_next;
      done  <= accept;
    end
    status <= status_next;
  end

  // The head slot and the count are already updated when done is high.
  assign is_empty      = (count == '0);
  assign head_value    = is_empty ? word_t'(0) : cell_value[0];
  assign head_priority = is_empty ? word_t'(0) : cell_prio[0];
  assign entry_count   = COUNT_W'(count);

endmodule
